FILE: design/fixed_slot_allocator_assert.svh
// Assertion macros shared by the slot allocator's checker.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef FIXED_SLOT_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fixed_slot_allocator check failed");

// Next-cycle implication, disabled in reset.
`define FSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fixed_slot_allocator check failed");

`endif

FILE: design/fsa_pkg.sv
// Package for the fixed slot allocator: widths, codes, reset values and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package fsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = IDX_W + 1;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int ALIGN_W    = 13;
  localparam int COUNT_W    = 11;
  localparam int SLOT_IDX_W = 10;
  localparam int STATUS_W   = 2;
  localparam int PITCH_W    = SIZE_W + 1;
  localparam int PROD_W     = PITCH_W + CNT_W;
  localparam int OFF_W      = PITCH_W + IDX_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(3);

  localparam logic [ADDR_W-1:0]  RST_BASE  = '0;
  localparam logic [SIZE_W-1:0]  RST_SIZE  = SIZE_W'(64);
  localparam logic [ALIGN_W-1:0] RST_ALIGN = ALIGN_W'(16);
  localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(1024);

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic                capture;
    logic                pop;
    logic                rel_mul;
    logic                div_start;
    logic                div_step;
    logic                push;
    logic                load;
    logic [STATUS_W-1:0] status;
  } fsa_cmd_t;

  typedef struct packed {
    logic empty;
    logic out_range;
    logic full;
  } fsa_sts_t;

endpackage
`default_nettype wire

FILE: design/fsa_in_if.sv
// Request channel of the slot allocator: valid/ready plus request payload.
// Depends on fsa_pkg.
`default_nettype none
interface fsa_in_if import fsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, kind, release_address, input ready);
  modport sink   (input valid, kind, release_address, output ready);
endinterface
`default_nettype wire

FILE: design/fsa_out_if.sv
// Response channel of the slot allocator: valid/ready plus response payload.
// Depends on fsa_pkg.
`default_nettype none
interface fsa_out_if import fsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_W-1:0]     slot_address;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, status, slot_address, slot_index, input ready);
  modport sink   (input valid, status, slot_address, slot_index, output ready);
endinterface
`default_nettype wire

FILE: design/fsa_cfg_if.sv
// Register write channel of the slot allocator: valid/ready, index and data.
// Depends on fsa_pkg.
`default_nettype none
interface fsa_cfg_if import fsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/fsa_ctrl.sv
// Sequencer of the slot allocator: steps allocate and release through the
// datapath and owns the response valid. Depends on fsa_pkg.
`default_nettype none
module fsa_ctrl
  import fsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_kind,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire fsa_sts_t sts,
  output fsa_cmd_t      cmd
);

  localparam int STATE_W = 3;
  localparam int STEP_W  = $clog2(IDX_W + 1);

  localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] S_A_RD   = 3'd1;
  localparam logic [STATE_W-1:0] S_A_MUL  = 3'd2;
  localparam logic [STATE_W-1:0] S_R_MUL  = 3'd3;
  localparam logic [STATE_W-1:0] S_R_CHK  = 3'd4;
  localparam logic [STATE_W-1:0] S_R_DIV  = 3'd5;
  localparam logic [STATE_W-1:0] S_R_PUSH = 3'd6;
  localparam logic [STATE_W-1:0] S_DONE   = 3'd7;

  logic [STATE_W-1:0]  state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [STATUS_W-1:0] res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.status = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == KIND_ALLOC) ? S_A_RD : S_R_MUL;
        end
      end
      S_A_RD: begin
        // stack top read settles here
        if (sts.empty) begin
          res_nxt   = ST_EMPTY;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_A_MUL;
        end
      end
      S_A_MUL: begin
        cmd.pop   = 1'b1;
        res_nxt   = ST_OK;
        state_nxt = S_DONE;
      end
      S_R_MUL: begin
        cmd.rel_mul = 1'b1;
        state_nxt   = S_R_CHK;
      end
      S_R_CHK: begin
        if (sts.out_range) begin
          res_nxt   = ST_RANGE;
          state_nxt = S_DONE;
        end else if (sts.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_R_DIV;
        end
      end
      S_R_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(IDX_W - 1)) begin
          state_nxt = S_R_PUSH;
        end
      end
      S_R_PUSH: begin
        cmd.push  = 1'b1;
        res_nxt   = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      res_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/fsa_dp.sv
// Datapath of the slot allocator: registers, free-index stack memory,
// pitch multiplier, restoring divider and response registers. Depends on fsa_pkg.
`default_nettype none
module fsa_dp
  import fsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fsa_cmd_t              cmd,
  output fsa_sts_t                   sts,
  input  wire logic                  in_kind,
  input  wire logic [ADDR_W-1:0]     in_release_address,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STATUS_W-1:0]        out_status,
  output logic [ADDR_W-1:0]          out_slot_address,
  output logic [SLOT_IDX_W-1:0]      out_slot_index
);

  logic [ADDR_W-1:0]     base_r;
  logic [SIZE_W-1:0]     size_r;
  logic [ALIGN_W-1:0]    align_r;
  logic [COUNT_W-1:0]    count_r;
  logic [CNT_W-1:0]      fc_r;
  logic [CNT_W-1:0]      low_r;     // stack slots below this still hold their refill value
  logic                  kind_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [PROD_W-1:0]     mul_r;
  logic [OFF_W-1:0]      off_r;
  logic [OFF_W-1:0]      rem_r;
  logic [OFF_W-1:0]      dvs_r;
  logic [IDX_W-1:0]      quo_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      rd_r;
  logic [IDX_W-1:0]      stack_mem [MAX_SLOTS];

  logic [STATUS_W-1:0]   ost_r;
  logic [ADDR_W-1:0]     oaddr_r;
  logic [SLOT_IDX_W-1:0] oidx_r;

  logic [ALIGN_W-1:0]    amask;
  logic [PITCH_W-1:0]    pitch;
  logic [CNT_W-1:0]      eff;
  logic [CNT_W-1:0]      new_eff;
  logic [IDX_W-1:0]      top;
  logic                  top_fresh;
  logic [IDX_W-1:0]      idx_sel;
  logic [CNT_W-1:0]      mul_b;
  logic [ADDR_W:0]       region_end;
  logic                  cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // alignment of zero behaves as one
  assign amask = (align_r == '0) ? '0 : align_r - ALIGN_W'(1);
  assign pitch = ({1'b0, size_r} + PITCH_W'(amask)) & ~PITCH_W'(amask);

  always_comb begin
    if (32'(count_r) > 32'(MAX_SLOTS)) begin
      eff = CNT_W'(MAX_SLOTS);
    end else begin
      eff = CNT_W'(count_r);
    end
    if (32'(cfg_data[COUNT_W-1:0]) > 32'(MAX_SLOTS)) begin
      new_eff = CNT_W'(MAX_SLOTS);
    end else begin
      new_eff = CNT_W'(cfg_data[COUNT_W-1:0]);
    end
  end

  assign top       = fc_r[IDX_W-1:0] - IDX_W'(1);
  assign top_fresh = ({1'b0, top} < low_r);
  assign idx_sel   = top_fresh ? top : rd_r;
  assign mul_b     = cmd.pop ? {1'b0, idx_sel} : eff;

  assign region_end = {1'b0, base_r} + (ADDR_W + 1)'(mul_r);

  assign sts.empty     = (fc_r == '0);
  assign sts.full      = (fc_r >= eff);
  assign sts.out_range = (pitch == '0) || (addr_r < base_r) ||
                         ({1'b0, addr_r} >= region_end);

  // configuration and stack bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE;
      size_r  <= RST_SIZE;
      align_r <= RST_ALIGN;
      count_r <= RST_COUNT;
      fc_r    <= CNT_W'(MAX_SLOTS);
      low_r   <= CNT_W'(MAX_SLOTS);
    end else begin
      if (cfg_xfer) begin
        case (cfg_index)
          REG_BASE:  base_r  <= cfg_data[ADDR_W-1:0];
          REG_SIZE:  size_r  <= cfg_data[SIZE_W-1:0];
          REG_ALIGN: align_r <= cfg_data[ALIGN_W-1:0];
          REG_COUNT: begin
            count_r <= cfg_data[COUNT_W-1:0];
            fc_r    <= new_eff;
            low_r   <= CNT_W'(MAX_SLOTS);
          end
          default: ;
        endcase
      end else if (cmd.pop) begin
        fc_r <= fc_r - CNT_W'(1);
        if (top_fresh) begin
          low_r <= {1'b0, top};
        end
      end else if (cmd.push) begin
        fc_r <= fc_r + CNT_W'(1);
      end
    end
  end

  // free-index stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[fc_r[IDX_W-1:0]] <= quo_r;
    end
    rd_r <= stack_mem[top];
  end

  // request capture, multiplier and divider
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      addr_r <= in_release_address;
    end
    if (cmd.pop || cmd.rel_mul) begin
      mul_r <= PROD_W'(pitch) * PROD_W'(mul_b);
    end
    if (cmd.rel_mul) begin
      off_r <= OFF_W'(addr_r - base_r);
    end
    if (cmd.pop) begin
      idx_r <= idx_sel;
    end else if (cmd.push) begin
      idx_r <= quo_r;
    end
    if (cmd.div_start) begin
      rem_r <= off_r;
      dvs_r <= OFF_W'({pitch, {(IDX_W - 1){1'b0}}});
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        quo_r <= {quo_r[IDX_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[IDX_W-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ost_r <= cmd.status;
      if (cmd.status == ST_OK && kind_r == KIND_ALLOC) begin
        oaddr_r <= base_r + ADDR_W'(mul_r);
      end else begin
        oaddr_r <= '0;
      end
      if (cmd.status == ST_OK) begin
        oidx_r <= SLOT_IDX_W'(idx_r);
      end else begin
        oidx_r <= '0;
      end
    end
  end

  assign out_status       = ost_r;
  assign out_slot_address = oaddr_r;
  assign out_slot_index   = oidx_r;

endmodule
`default_nettype wire

FILE: design/fixed_slot_allocator.sv
// Fixed-size slot allocator, top level: joins sequencer and datapath to the
// request, response and register channels. Depends on fsa_pkg, fsa_ctrl, fsa_dp.
//
// Usage:
//   in_ch  : requests. kind 0 allocates a slot, kind 1 releases release_address.
//   out_ch : one response per request, in order: status, slot_address, slot_index.
//   cfg_ch : register writes (index 0 base, 1 slot size, 2 alignment, 3 slot
//            count). Writing the slot count refills the free stack. Always ready;
//            write only while no request is in flight.
// Sequence: one request at a time. An allocate passes from the transfer to the
//   response through stack read, multiply and response load; with no slot free
//   it skips the multiply. A release runs a multiply for the region end, a range
//   and full check, then a restoring divide by the slot pitch at one quotient bit
//   per cycle and the stack push. Failed releases skip the divide and the push.
// The response register frees the sequencer: a new request is taken while the
//   previous response still waits. If out_ch stalls with a response held and a
//   second one finished, the second waits in the sequencer and in_ch stays low.
// Reset (rst_n, synchronous): registers take defaults (base 0, size 64,
//   alignment 16, 1024 slots); all 1024 slots are free, index 1023 first.
`default_nettype none
module fixed_slot_allocator
  import fsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fsa_in_if.sink     in_ch,
  fsa_out_if.source  out_ch,
  fsa_cfg_if.sink    cfg_ch
);

  fsa_cmd_t cmd;
  fsa_sts_t sts;

  fsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_ch.kind),
    .in_release_address (in_ch.release_address),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_status         (out_ch.status),
    .out_slot_address   (out_ch.slot_address),
    .out_slot_index     (out_ch.slot_index)
  );

endmodule
`default_nettype wire

FILE: design/fsa_checker.sv
// Port-level checker for the slot allocator, attached to the top by bind.
// Depends on fsa_pkg and fixed_slot_allocator_assert.svh.
`default_nettype none
`include "fixed_slot_allocator_assert.svh"
module fsa_checker
  import fsa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [STATUS_W-1:0]   out_status,
  input wire logic [ADDR_W-1:0]     out_slot_address,
  input wire logic [SLOT_IDX_W-1:0] out_slot_index
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r, pend_nxt;   // requests taken, response not yet transferred

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `FSA_ASSERT_NOW(a_no_spurious_resp, out_valid, pend_r != 2'd0)
  `FSA_ASSERT_NOW(a_two_in_flight_max, in_xfer, pend_r != 2'd2)
  `FSA_ASSERT_NEXT(a_one_at_a_time, in_xfer, !in_ready)
  `FSA_ASSERT_NOW(a_fail_zeroes, out_valid && out_status != ST_OK,
                  out_slot_address == '0 && out_slot_index == '0)
  `FSA_ASSERT_NEXT(a_resp_held, out_valid && !out_ready, out_valid)

endmodule

bind fixed_slot_allocator fsa_checker u_fsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_slot_address (out_ch.slot_address),
  .out_slot_index   (out_ch.slot_index)
);
`default_nettype wire
